@@ src/strided_slice_address_generator_defines.svh @@
// Assertion macros for the strided slice address generator.
// Included by the top level; no other dependencies.
// Under SYNTHESIS the macros expand to nothing.
`ifndef STRIDED_SLICE_ADDRESS_GENERATOR_DEFINES_SVH
`define STRIDED_SLICE_ADDRESS_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SSAG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssag: same-cycle check failed");

// next-cycle implication
`define SSAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssag: next-cycle check failed");

`else

`define SSAG_ASSERT_NOW(label, clk, rst, ante, cons)
`define SSAG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/ssag_pkg.sv @@
// Shared constants, types and helper functions for the strided slice
// address generator. No dependencies.
`default_nettype none

package ssag_pkg;

   // block sizing
   localparam int AXES        = 4;
   localparam int AXIS_BITS   = 16;
   localparam int OFFSET_BITS = 32;

   // register layout: four 16-bit slots, slot 0 in the top bits
   localparam int SLOT_BITS      = 16;
   localparam int SLOTS          = 4;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_DATA_BITS-1:0] CSR_ONES_RESET = 64'h0001_0001_0001_0001;

   // result widths
   localparam int SRC_BITS     = 32;
   localparam int OUT_POS_BITS = 32;
   localparam int LIMIT_BITS   = (OFFSET_BITS < SRC_BITS) ? OFFSET_BITS : SRC_BITS;
   localparam logic [SRC_BITS-1:0] SRC_LIMIT =
      SRC_BITS'((64'd1 << LIMIT_BITS) - 64'd1);

   // offset datapath depth
   localparam int PIPE_STAGES = 7;

   // datapath widths
   localparam int IDX_BITS    = 2 * AXIS_BITS + 1;
   localparam int MAG_BITS    = 2 * AXIS_BITS;
   localparam int PAIR_BITS   = 2 * AXIS_BITS;
   localparam int STRIDE_BITS = 3 * AXIS_BITS;
   localparam int HALF_BITS   = (STRIDE_BITS + 1) / 2;
   localparam int HIGH_BITS   = STRIDE_BITS - HALF_BITS;
   localparam int PP_LO_BITS  = MAG_BITS + HALF_BITS;
   localparam int PP_HI_BITS  = MAG_BITS + HIGH_BITS;
   localparam int CAP_SHIFT   = 60;
   localparam int PROD_BITS   = (MAG_BITS + STRIDE_BITS > CAP_SHIFT + 1) ?
                                MAG_BITS + STRIDE_BITS : CAP_SHIFT + 1;
   localparam int TERM_BITS   = CAP_SHIFT + 1;
   localparam int SUM_BITS    = TERM_BITS + 3;
   localparam int PAD_TERMS   = 4;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_AXIS_BEGINS = 3'd0,
      CSR_AXIS_STEPS  = 3'd1,
      CSR_OUT_COUNTS  = 3'd2,
      CSR_IN_EXTENTS  = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] begins;
      logic [CSR_DATA_BITS-1:0] steps;
      logic [CSR_DATA_BITS-1:0] counts;
      logic [CSR_DATA_BITS-1:0] extents;
   } cfg_type;

   typedef logic [AXES-1:0][AXIS_BITS-1:0] axis_pos_type;

   // odometer word handed to the offset datapath
   typedef struct packed {
      axis_pos_type            pos;
      logic [OUT_POS_BITS-1:0] out_position;
      logic                    last;
   } odo_word_type;

   // result word
   typedef struct packed {
      logic [SRC_BITS-1:0]     source_offset;
      logic [OUT_POS_BITS-1:0] out_position;
      logic                    last_element;
      logic                    range_error;
   } rsp_word_type;

   // slot of axis a, low AXIS_BITS only
   function automatic logic [AXIS_BITS-1:0] slot_of(input logic [CSR_DATA_BITS-1:0] r,
                                                    input int a);
      logic [CSR_DATA_BITS-1:0] sh;
      sh = r >> (SLOT_BITS * (SLOTS - 1 - a));
      return sh[AXIS_BITS-1:0];
   endfunction

   // zero counts and extents behave as one
   function automatic logic [AXIS_BITS-1:0] nonzero(input logic [AXIS_BITS-1:0] v);
      logic [AXIS_BITS-1:0] one;
      one = {{(AXIS_BITS-1){1'b0}}, 1'b1};
      return (v == '0) ? one : v;
   endfunction

   // extent of axis a, one for axes past the last
   function automatic logic [AXIS_BITS-1:0] extent_or_one(
      input logic [CSR_DATA_BITS-1:0] r, input int a);
      logic [AXIS_BITS-1:0] one;
      one = {{(AXIS_BITS-1){1'b0}}, 1'b1};
      if (a < AXES) begin
         return nonzero(slot_of(r, a));
      end
      return one;
   endfunction

   // source index on one axis: origin + pos * step
   function automatic logic signed [IDX_BITS-1:0] axis_index(
      input logic [AXIS_BITS-1:0] origin,
      input logic [AXIS_BITS-1:0] step_raw,
      input logic [AXIS_BITS-1:0] pos);
      logic signed [AXIS_BITS:0]   pos_s;
      logic signed [AXIS_BITS-1:0] step_s;
      logic signed [IDX_BITS-1:0]  prod;
      logic signed [IDX_BITS-1:0]  org_s;
      pos_s  = {1'b0, pos};
      step_s = step_raw;
      prod   = pos_s * step_s;
      org_s  = {{(IDX_BITS-AXIS_BITS){1'b0}}, origin};
      return prod + org_s;
   endfunction

endpackage

`default_nettype wire

@@ src/ssag_odometer.sv @@
// Destination odometer: axis positions and output counter, advanced once
// per accepted word. Depends on ssag_pkg.
`default_nettype none

module ssag_odometer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic                                restart,
   input  wire logic [ssag_pkg::CSR_DATA_BITS-1:0]  out_counts,
   output ssag_pkg::odo_word_type                   word
);

   ssag_pkg::axis_pos_type                 pos_ff, pos_in, eff_pos;
   logic [ssag_pkg::OUT_POS_BITS-1:0]      count_ff, count_in, eff_count;
   logic [ssag_pkg::AXES-1:0]              at_end;
   logic                                   last;

   // current position (after restart), end flags and the advanced position
   always_comb begin
      logic carry;
      carry     = 1'b1;
      eff_pos   = restart ? '0 : pos_ff;
      eff_count = restart ? '0 : count_ff;
      for (int a = 0; a < ssag_pkg::AXES; a++) begin
         at_end[a] = ({1'b0, eff_pos[a]} + {{ssag_pkg::AXIS_BITS{1'b0}}, 1'b1}) >=
                     {1'b0, ssag_pkg::nonzero(ssag_pkg::slot_of(out_counts, a))};
      end
      last   = &at_end;
      pos_in = eff_pos;
      // last axis fastest; carry ripples toward axis 0
      for (int a = ssag_pkg::AXES - 1; a >= 0; a--) begin
         if (carry) begin
            if (at_end[a]) begin
               pos_in[a] = '0;
            end else begin
               pos_in[a] = eff_pos[a] + {{(ssag_pkg::AXIS_BITS-1){1'b0}}, 1'b1};
               carry     = 1'b0;
            end
         end
      end
      count_in = last ? '0 : eff_count + {{(ssag_pkg::OUT_POS_BITS-1){1'b0}}, 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   assign word.pos          = eff_pos;
   assign word.out_position = eff_count;
   assign word.last         = last;

endmodule

`default_nettype wire

@@ src/ssag_offset_pipe.sv @@
// Seven-stage elastic datapath: odometer word to saturated source offset.
// Depends on ssag_pkg.
`default_nettype none

module ssag_offset_pipe (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire ssag_pkg::odo_word_type  in_word,
   input  wire ssag_pkg::cfg_type       cfg,
   input  wire logic                    out_stall,
   output logic                         in_ready,
   output logic                         out_valid,
   output ssag_pkg::rsp_word_type       out_word
);

   typedef struct packed {
      logic [ssag_pkg::OUT_POS_BITS-1:0] out_position;
      logic                              last;
   } tag_type;

   // stage control
   logic [ssag_pkg::PIPE_STAGES:1] v_ff, v_src, ready;

   always_comb begin
      ready[ssag_pkg::PIPE_STAGES] = !v_ff[ssag_pkg::PIPE_STAGES] || !out_stall;
      for (int k = ssag_pkg::PIPE_STAGES - 1; k >= 1; k--) begin
         ready[k] = !v_ff[k] || ready[k+1];
      end
      v_src[1] = in_valid;
      for (int k = 2; k <= ssag_pkg::PIPE_STAGES; k++) begin
         v_src[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= ssag_pkg::PIPE_STAGES; k++) begin
            if (ready[k]) begin
               v_ff[k] <= v_src[k];
            end
         end
      end
   end

   assign in_ready  = ready[1];
   assign out_valid = v_ff[ssag_pkg::PIPE_STAGES];

   // stage 1: odometer word
   ssag_pkg::odo_word_type s1_word_ff;
   tag_type                s1_tag;

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         s1_word_ff <= in_word;
      end
   end

   assign s1_tag.out_position = s1_word_ff.out_position;
   assign s1_tag.last         = s1_word_ff.last;

   // stage 2: per-axis source index, pairwise extent products
   logic signed [ssag_pkg::IDX_BITS-1:0]  s2_idx_in  [ssag_pkg::AXES];
   logic signed [ssag_pkg::IDX_BITS-1:0]  s2_idx_ff  [ssag_pkg::AXES];
   logic [ssag_pkg::PAIR_BITS-1:0]        s2_pair_in [ssag_pkg::AXES];
   logic [ssag_pkg::PAIR_BITS-1:0]        s2_pair_ff [ssag_pkg::AXES];
   tag_type                               s2_tag_ff;

   always_comb begin
      for (int a = 0; a < ssag_pkg::AXES; a++) begin
         s2_idx_in[a] = ssag_pkg::axis_index(ssag_pkg::slot_of(cfg.begins, a),
                                             ssag_pkg::slot_of(cfg.steps, a),
                                             s1_word_ff.pos[a]);
         s2_pair_in[a] =
            {{ssag_pkg::AXIS_BITS{1'b0}}, ssag_pkg::extent_or_one(cfg.extents, a + 1)} *
            {{ssag_pkg::AXIS_BITS{1'b0}}, ssag_pkg::extent_or_one(cfg.extents, a + 2)};
      end
   end

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         s2_idx_ff  <= s2_idx_in;
         s2_pair_ff <= s2_pair_in;
         s2_tag_ff  <= s1_tag;
      end
   end

   // stage 3: index magnitude and sign, full stride
   logic [ssag_pkg::MAG_BITS-1:0]     s3_mag_in    [ssag_pkg::AXES];
   logic [ssag_pkg::MAG_BITS-1:0]     s3_mag_ff    [ssag_pkg::AXES];
   logic [ssag_pkg::STRIDE_BITS-1:0]  s3_stride_in [ssag_pkg::AXES];
   logic [ssag_pkg::STRIDE_BITS-1:0]  s3_stride_ff [ssag_pkg::AXES];
   logic [ssag_pkg::AXES-1:0]         s3_neg_in, s3_neg_ff;
   tag_type                           s3_tag_ff;

   always_comb begin
      logic signed [ssag_pkg::IDX_BITS-1:0] negv;
      negv = '0;
      for (int a = 0; a < ssag_pkg::AXES; a++) begin
         negv          = -s2_idx_ff[a];
         s3_neg_in[a]  = s2_idx_ff[a][ssag_pkg::IDX_BITS-1];
         s3_mag_in[a]  = s3_neg_in[a] ? negv[ssag_pkg::MAG_BITS-1:0]
                                      : s2_idx_ff[a][ssag_pkg::MAG_BITS-1:0];
         s3_stride_in[a] =
            {{ssag_pkg::AXIS_BITS{1'b0}}, s2_pair_ff[a]} *
            {{ssag_pkg::PAIR_BITS{1'b0}}, ssag_pkg::extent_or_one(cfg.extents, a + 3)};
      end
   end

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         s3_mag_ff    <= s3_mag_in;
         s3_stride_ff <= s3_stride_in;
         s3_neg_ff    <= s3_neg_in;
         s3_tag_ff    <= s2_tag_ff;
      end
   end

   // stage 4: magnitude times stride, as two partial products
   logic [ssag_pkg::PP_LO_BITS-1:0]  s4_lo_in [ssag_pkg::AXES];
   logic [ssag_pkg::PP_LO_BITS-1:0]  s4_lo_ff [ssag_pkg::AXES];
   logic [ssag_pkg::PP_HI_BITS-1:0]  s4_hi_in [ssag_pkg::AXES];
   logic [ssag_pkg::PP_HI_BITS-1:0]  s4_hi_ff [ssag_pkg::AXES];
   logic [ssag_pkg::AXES-1:0]        s4_neg_ff;
   tag_type                          s4_tag_ff;

   always_comb begin
      for (int a = 0; a < ssag_pkg::AXES; a++) begin
         s4_lo_in[a] =
            {{ssag_pkg::HALF_BITS{1'b0}}, s3_mag_ff[a]} *
            {{ssag_pkg::MAG_BITS{1'b0}}, s3_stride_ff[a][ssag_pkg::HALF_BITS-1:0]};
         s4_hi_in[a] =
            {{ssag_pkg::HIGH_BITS{1'b0}}, s3_mag_ff[a]} *
            {{ssag_pkg::MAG_BITS{1'b0}},
             s3_stride_ff[a][ssag_pkg::STRIDE_BITS-1:ssag_pkg::HALF_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         s4_lo_ff  <= s4_lo_in;
         s4_hi_ff  <= s4_hi_in;
         s4_neg_ff <= s3_neg_ff;
         s4_tag_ff <= s3_tag_ff;
      end
   end

   // stage 5: combine partial products, check against the 2^60 cap
   logic [ssag_pkg::PROD_BITS-1:0]  prod [ssag_pkg::AXES];
   logic [ssag_pkg::PROD_BITS-1:0]  cap_ref;
   logic [ssag_pkg::TERM_BITS-1:0]  s5_mag_ff [ssag_pkg::AXES];
   logic [ssag_pkg::AXES-1:0]       s5_capped_in, s5_capped_ff, s5_neg_ff;
   tag_type                         s5_tag_ff;

   always_comb begin
      cap_ref                     = '0;
      cap_ref[ssag_pkg::CAP_SHIFT] = 1'b1;
      for (int a = 0; a < ssag_pkg::AXES; a++) begin
         prod[a] = {{(ssag_pkg::PROD_BITS-ssag_pkg::PP_LO_BITS){1'b0}}, s4_lo_ff[a]} +
                   ({{(ssag_pkg::PROD_BITS-ssag_pkg::PP_HI_BITS){1'b0}}, s4_hi_ff[a]}
                    << ssag_pkg::HALF_BITS);
         s5_capped_in[a] = prod[a] > cap_ref;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[5]) begin
         for (int a = 0; a < ssag_pkg::AXES; a++) begin
            s5_mag_ff[a] <= prod[a][ssag_pkg::TERM_BITS-1:0];
         end
         s5_capped_ff <= s5_capped_in;
         s5_neg_ff    <= s4_neg_ff;
         s5_tag_ff    <= s4_tag_ff;
      end
   end

   // stage 6: signed terms, pair sums
   logic signed [ssag_pkg::SUM_BITS-1:0] term [ssag_pkg::PAD_TERMS];
   logic signed [ssag_pkg::SUM_BITS-1:0] s6_sum_ff [2];
   logic                                 s6_cap_ff;
   tag_type                              s6_tag_ff;

   always_comb begin
      logic signed [ssag_pkg::SUM_BITS-1:0] ext;
      ext = '0;
      for (int t = 0; t < ssag_pkg::PAD_TERMS; t++) begin
         term[t] = '0;
      end
      for (int a = 0; a < ssag_pkg::AXES; a++) begin
         ext     = {{(ssag_pkg::SUM_BITS-ssag_pkg::TERM_BITS){1'b0}}, s5_mag_ff[a]};
         term[a] = s5_neg_ff[a] ? -ext : ext;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[6]) begin
         s6_sum_ff[0] <= term[0] + term[1];
         s6_sum_ff[1] <= term[2] + term[3];
         s6_cap_ff    <= |s5_capped_ff;
         s6_tag_ff    <= s5_tag_ff;
      end
   end

   // stage 7: total and saturation into the result register
   logic signed [ssag_pkg::SUM_BITS-1:0] total;
   ssag_pkg::rsp_word_type               s7_word_in, s7_word_ff;

   always_comb begin
      logic [ssag_pkg::SRC_BITS-1:0] low;
      low                           = '0;
      total                         = s6_sum_ff[0] + s6_sum_ff[1];
      low[ssag_pkg::LIMIT_BITS-1:0] = total[ssag_pkg::LIMIT_BITS-1:0];
      s7_word_in.out_position       = s6_tag_ff.out_position;
      s7_word_in.last_element       = s6_tag_ff.last;
      if (s6_cap_ff) begin
         s7_word_in.source_offset = ssag_pkg::SRC_LIMIT;
         s7_word_in.range_error   = 1'b1;
      end else if (total[ssag_pkg::SUM_BITS-1]) begin
         s7_word_in.source_offset = '0;
         s7_word_in.range_error   = 1'b1;
      end else if (|total[ssag_pkg::SUM_BITS-2:ssag_pkg::LIMIT_BITS]) begin
         s7_word_in.source_offset = ssag_pkg::SRC_LIMIT;
         s7_word_in.range_error   = 1'b1;
      end else begin
         s7_word_in.source_offset = low;
         s7_word_in.range_error   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[7]) begin
         s7_word_ff <= s7_word_in;
      end
   end

   assign out_word = s7_word_ff;

endmodule

`default_nettype wire

@@ src/strided_slice_address_generator.sv @@
// Top level of the strided slice address generator: configuration
// registers, odometer and offset datapath. Depends on ssag_pkg,
// ssag_odometer, ssag_offset_pipe and the assertion macro header.
//
// Usage: each word accepted on req_* (valid/stall) produces one result
// word on rsp_*: the source offset of the next slice element in row-major
// destination order, its destination index, a last flag and a range error.
// req_restart=1 rewinds to element zero before that word is processed.
// Configuration is written through csr_write/csr_index/csr_wdata while no
// words are in flight (the user's duty; not enforced); writes do not move the odometer.
// Throughput: one word per clock unless stalled. The offset datapath is seven
// register stages (odometer word, index multiply, stride products, split
// stride multiply, cap check, pair sums, total and saturation), and a result
// is on rsp_* once its word has passed through all of them in this order.
// Stalls: up to seven words are held; outside reset, req_stall rises only when
// every stage is full and rsp_stall is high; a stalled result word holds steady.
// Reset (synchronous): odometer back to element zero, registers to their
// defaults, datapath emptied; req_stall stays high while reset is high.
`default_nettype none

`include "strided_slice_address_generator_defines.svh"

module strided_slice_address_generator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_restart,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [ssag_pkg::SRC_BITS-1:0]             rsp_source_offset,
   output logic [ssag_pkg::OUT_POS_BITS-1:0]         rsp_out_position,
   output logic                                      rsp_last_element,
   output logic                                      rsp_range_error,
   // configuration port
   input  wire logic                                 csr_write,
   input  wire logic [ssag_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ssag_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   ssag_pkg::cfg_type       cfg_ff;
   ssag_pkg::odo_word_type  odo_word;
   ssag_pkg::rsp_word_type  rsp_word;
   logic                    pipe_ready;
   logic                    accept;

   // configuration registers; unused indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.begins  <= '0;
         cfg_ff.steps   <= ssag_pkg::CSR_ONES_RESET;
         cfg_ff.counts  <= ssag_pkg::CSR_ONES_RESET;
         cfg_ff.extents <= ssag_pkg::CSR_ONES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ssag_pkg::CSR_AXIS_BEGINS: cfg_ff.begins  <= csr_wdata;
            ssag_pkg::CSR_AXIS_STEPS:  cfg_ff.steps   <= csr_wdata;
            ssag_pkg::CSR_OUT_COUNTS:  cfg_ff.counts  <= csr_wdata;
            ssag_pkg::CSR_IN_EXTENTS:  cfg_ff.extents <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request handshake
   assign req_stall = reset || !pipe_ready;
   assign accept    = req_valid && !req_stall;

   ssag_odometer u_odometer (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .restart    (req_restart),
      .out_counts (cfg_ff.counts),
      .word       (odo_word)
   );

   ssag_offset_pipe u_offset_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (odo_word),
      .cfg       (cfg_ff),
      .out_stall (rsp_stall),
      .in_ready  (pipe_ready),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

   assign rsp_source_offset = rsp_word.source_offset;
   assign rsp_out_position  = rsp_word.out_position;
   assign rsp_last_element  = rsp_word.last_element;
   assign rsp_range_error   = rsp_word.range_error;

   // checks
   `SSAG_ASSERT_NEXT(a_wrap_after_last, clock, reset,
      accept && odo_word.last, odo_word.out_position == '0)
   `SSAG_ASSERT_NEXT(a_counter_steps, clock, reset,
      accept && !odo_word.last,
      req_restart || (odo_word.out_position == $past(odo_word.out_position) + 32'd1))
   `SSAG_ASSERT_NOW(a_saturated_value, clock, reset,
      rsp_valid && rsp_range_error,
      rsp_source_offset == '0 || rsp_source_offset == ssag_pkg::SRC_LIMIT)
   `SSAG_ASSERT_NOW(a_stall_only_when_full, clock, reset,
      req_stall, rsp_valid && rsp_stall)

endmodule

`default_nettype wire
